>>> rtl/core/cwpl_pkg.sv
// Shared types and codes for the channel word pool ledger.
package cwpl_pkg;

    // Width of the shared arithmetic unit: holds a TX request of up to
    // fifteen blocks of 127 words and the sum of both reservations.
    localparam int ALU_W = 11;

    typedef logic [ALU_W-1:0] t_alu_word;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB_SAT
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSUM,
        S_XTX,
        S_XRX,
        S_AVAIL,
        S_FIT,
        S_COMMIT,
        S_FTX,
        S_FRX
    } t_step;

    typedef struct packed {
        logic  busy;
        logic  last;
        t_step step;
    } t_seq_ctl;

    // Request kinds.
    localparam logic [2:0] K_ALLOC   = 3'd0;
    localparam logic [2:0] K_FREE    = 3'd1;
    localparam logic [2:0] K_QUERY   = 3'd2;
    localparam logic [2:0] K_CLEAR   = 3'd3;
    localparam logic [2:0] K_DMA_GET = 3'd4;
    localparam logic [2:0] K_DMA_PUT = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_ALREADY      = 3'd1;
    localparam logic [2:0] ST_NO_TX_ROOM   = 3'd2;
    localparam logic [2:0] ST_NO_RX_ROOM   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd4;
    localparam logic [2:0] ST_DMA_BUSY     = 3'd5;
    localparam logic [2:0] ST_DMA_NOT_HELD = 3'd6;
    localparam logic [2:0] ST_DMA_MISMATCH = 3'd7;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SHARED     = 3'd0;
    localparam logic [2:0] REG_TX_POOL    = 3'd1;
    localparam logic [2:0] REG_RX_POOL    = 3'd2;
    localparam logic [2:0] REG_TX_RESV    = 3'd3;
    localparam logic [2:0] REG_RX_RESV    = 3'd4;
    localparam logic [2:0] REG_BLOCK_W    = 3'd5;
    localparam logic [2:0] REG_IDLE_BLK   = 3'd6;
    localparam logic [2:0] REG_NET_BLK    = 3'd7;

endpackage

>>> rtl/core/channel_word_pool_ledger.sv
// Top level of the channel word pool ledger: registers, ledger table and datapath.
//
// The block keeps account of channel buffer words for up to CHANNELS channels in
// each direction. A request is taken on a rising edge with start high and busy
// low; busy then stays high while one shared add and saturating subtract unit
// works through the request a step at a time (reservation sum, TX and RX
// headroom, availability, fit check, counter update, and the two free-word
// figures). The result is on the output ports for exactly one cycle, marked by
// o_valid, registered from the last step, in the cycle in which busy has just
// fallen, so a new request may be started while a result is shown. The eight
// steps of the shared unit are followed by the output register. There is no
// back-pressure on results: the receiver must take each transfer in the cycle
// it is shown. Configuration registers must be written over the APB-style port
// only while no request is in flight; the block itself does not enforce this.
// pready is always high and reads return the register values.
module channel_word_pool_ledger #(
    parameter int CHANNELS   = 8,
    parameter int POOL_LIMIT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_channel,
    input  logic        i_is_transmit,
    input  logic        i_via_dma,
    input  logic        i_network_on,
    input  logic [9:0]  i_rx_symbols,
    // Result
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [9:0]  o_granted_words,
    output logic [9:0]  o_tx_free_words,
    output logic [9:0]  o_rx_free_words,
    output logic        o_dma_busy
);

    localparam int ENTRIES = 2 * CHANNELS;
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Pool sizes are ten-bit registers, so a limit above their range never bites.
    localparam int CAP_I   = (POOL_LIMIT > 1023) ? 1023 : POOL_LIMIT;
    localparam logic [9:0] CAP_W = 10'(CAP_I);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       r_shared;
    logic [9:0] r_tx_pool;
    logic [9:0] r_rx_pool;
    logic [9:0] r_tx_resv;
    logic [9:0] r_rx_resv;
    logic [6:0] r_block_w;
    logic [3:0] r_idle_blk;
    logic [3:0] r_net_blk;

    logic       w_cfg_wr;
    logic [2:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shared   <= 1'b0;
            r_tx_pool  <= 10'd96;
            r_rx_pool  <= 10'd96;
            r_tx_resv  <= 10'd0;
            r_rx_resv  <= 10'd0;
            r_block_w  <= 7'd48;
            r_idle_blk <= 4'd2;
            r_net_blk  <= 4'd3;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                cwpl_pkg::REG_SHARED:   r_shared   <= pwdata[0];
                cwpl_pkg::REG_TX_POOL:  r_tx_pool  <= pwdata[9:0];
                cwpl_pkg::REG_RX_POOL:  r_rx_pool  <= pwdata[9:0];
                cwpl_pkg::REG_TX_RESV:  r_tx_resv  <= pwdata[9:0];
                cwpl_pkg::REG_RX_RESV:  r_rx_resv  <= pwdata[9:0];
                cwpl_pkg::REG_BLOCK_W:  r_block_w  <= pwdata[6:0];
                cwpl_pkg::REG_IDLE_BLK: r_idle_blk <= pwdata[3:0];
                cwpl_pkg::REG_NET_BLK:  r_net_blk  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            cwpl_pkg::REG_SHARED:   prdata = {31'b0, r_shared};
            cwpl_pkg::REG_TX_POOL:  prdata = {22'b0, r_tx_pool};
            cwpl_pkg::REG_RX_POOL:  prdata = {22'b0, r_rx_pool};
            cwpl_pkg::REG_TX_RESV:  prdata = {22'b0, r_tx_resv};
            cwpl_pkg::REG_RX_RESV:  prdata = {22'b0, r_rx_resv};
            cwpl_pkg::REG_BLOCK_W:  prdata = {25'b0, r_block_w};
            cwpl_pkg::REG_IDLE_BLK: prdata = {28'b0, r_idle_blk};
            cwpl_pkg::REG_NET_BLK:  prdata = {28'b0, r_net_blk};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    cwpl_pkg::t_seq_ctl w_ctl;
    logic               w_go;

    assign busy = w_ctl.busy;
    assign w_go = start && !w_ctl.busy;

    cwpl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .o_ctl   (w_ctl)
    );

    // ------------------------------------------------------------------
    // Captured request. The word count a TX allocation needs is formed here
    // from the small block product, so later steps see one figure.
    // ------------------------------------------------------------------
    logic [2:0]  r_kind;
    logic [2:0]  r_ch;
    logic        r_tx;
    logic        r_in_range;
    logic [IW-1:0] r_idx;
    logic [10:0] r_need;

    logic [3:0]  w_blocks;
    logic [10:0] w_tx_need;
    logic [10:0] w_need;

    assign w_blocks  = i_network_on ? r_net_blk : r_idle_blk;
    assign w_tx_need = {7'b0, w_blocks} * {4'b0, r_block_w};
    assign w_need    = i_via_dma     ? 11'd0 :
                       i_is_transmit ? w_tx_need : {1'b0, i_rx_symbols};

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_kind     <= i_kind;
            r_ch       <= i_channel;
            r_tx       <= i_is_transmit;
            r_in_range <= (int'(i_channel) < CHANNELS);
            r_idx      <= IW'({i_channel, i_is_transmit});
            r_need     <= w_need;
        end
    end

    // ------------------------------------------------------------------
    // Ledger state
    // ------------------------------------------------------------------
    logic [ENTRIES-1:0] r_valid;
    logic [9:0]         r_words [ENTRIES];
    logic [9:0]         r_used_sh;
    logic [9:0]         r_used_tx;
    logic [9:0]         r_used_rx;
    logic               r_dma_held;
    logic [2:0]         r_dma_ch;
    logic               r_dma_tx;

    // Working registers of the step sequence.
    logic [10:0] r_rsum;
    logic [9:0]  r_xtx;
    logic [9:0]  r_xrx;
    logic [9:0]  r_avail;
    logic [9:0]  r_txf;
    logic [2:0]  r_status;
    logic [9:0]  r_granted;
    logic        r_upd;

    logic [9:0] w_tx_cap;
    logic [9:0] w_rx_cap;
    logic [9:0] w_used_sel;
    logic [9:0] w_x_sel;
    logic       w_entry_valid;
    logic [9:0] w_entry_words;

    assign w_tx_cap = (r_tx_pool > CAP_W) ? CAP_W : r_tx_pool;
    assign w_rx_cap = (r_rx_pool > CAP_W) ? CAP_W : r_rx_pool;

    // In shared mode both directions draw on the one counter and one headroom.
    assign w_used_sel = r_shared ? r_used_sh : (r_tx ? r_used_tx : r_used_rx);
    assign w_x_sel    = (r_shared || r_tx) ? r_xtx : r_xrx;

    assign w_entry_valid = r_valid[r_idx];
    assign w_entry_words = r_words[r_idx];

    // ------------------------------------------------------------------
    // Shared unit operand selection
    // ------------------------------------------------------------------
    cwpl_pkg::t_alu_op   w_op;
    cwpl_pkg::t_alu_word w_a;
    cwpl_pkg::t_alu_word w_b;
    cwpl_pkg::t_alu_word w_res;
    logic                w_borrow;

    always_comb begin
        w_op = cwpl_pkg::ALU_SUB_SAT;
        w_a  = '0;
        w_b  = '0;
        unique case (w_ctl.step)
            cwpl_pkg::S_RSUM: begin
                w_op = cwpl_pkg::ALU_ADD;
                w_a  = {1'b0, r_tx_resv};
                w_b  = {1'b0, r_rx_resv};
            end
            cwpl_pkg::S_XTX: begin
                w_a = {1'b0, w_tx_cap};
                w_b = r_shared ? r_rsum : {1'b0, r_tx_resv};
            end
            cwpl_pkg::S_XRX: begin
                w_a = {1'b0, w_rx_cap};
                w_b = {1'b0, r_rx_resv};
            end
            cwpl_pkg::S_AVAIL: begin
                w_a = {1'b0, w_x_sel};
                w_b = {1'b0, w_used_sel};
            end
            cwpl_pkg::S_FIT: begin
                // Borrow means the request does not fit the availability.
                w_a = {1'b0, r_avail};
                w_b = r_need;
            end
            cwpl_pkg::S_COMMIT: begin
                w_op = (r_kind == cwpl_pkg::K_ALLOC) ? cwpl_pkg::ALU_ADD
                                                     : cwpl_pkg::ALU_SUB_SAT;
                w_a  = {1'b0, w_used_sel};
                w_b  = {1'b0, r_granted};
            end
            cwpl_pkg::S_FTX: begin
                w_a = {1'b0, r_xtx};
                w_b = {1'b0, r_shared ? r_used_sh : r_used_tx};
            end
            cwpl_pkg::S_FRX: begin
                w_a = {1'b0, r_shared ? r_xtx : r_xrx};
                w_b = {1'b0, r_shared ? r_used_sh : r_used_rx};
            end
            cwpl_pkg::S_IDLE: ;
            default: ;
        endcase
    end

    cwpl_alu u_alu (
        .i_op     (w_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_res    (w_res),
        .o_borrow (w_borrow)
    );

    // ------------------------------------------------------------------
    // Step results and ledger updates
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (w_ctl.step)
            cwpl_pkg::S_RSUM:  r_rsum  <= w_res;
            cwpl_pkg::S_XTX:   r_xtx   <= w_res[9:0];
            cwpl_pkg::S_XRX:   r_xrx   <= w_res[9:0];
            cwpl_pkg::S_AVAIL: r_avail <= w_res[9:0];
            cwpl_pkg::S_FTX:   r_txf   <= w_res[9:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_used_sh  <= '0;
            r_used_tx  <= '0;
            r_used_rx  <= '0;
            r_dma_held <= 1'b0;
            r_dma_ch   <= '0;
            r_dma_tx   <= 1'b0;
            r_upd      <= 1'b0;
            r_status   <= cwpl_pkg::ST_OK;
            r_granted  <= '0;
        end else if (w_ctl.step == cwpl_pkg::S_FIT) begin
            r_status  <= cwpl_pkg::ST_OK;
            r_granted <= '0;
            r_upd     <= 1'b0;
            priority if ((r_kind == cwpl_pkg::K_ALLOC || r_kind == cwpl_pkg::K_FREE ||
                          r_kind == cwpl_pkg::K_QUERY) && !r_in_range) begin
                r_status <= cwpl_pkg::ST_NOT_FOUND;
            end else if (r_kind == cwpl_pkg::K_ALLOC) begin
                priority if (w_entry_valid) begin
                    r_status <= cwpl_pkg::ST_ALREADY;
                end else if (w_borrow) begin
                    r_status <= r_tx ? cwpl_pkg::ST_NO_TX_ROOM : cwpl_pkg::ST_NO_RX_ROOM;
                end else begin
                    // A fitting request never exceeds ten bits.
                    r_valid[r_idx] <= 1'b1;
                    r_words[r_idx] <= r_need[9:0];
                    r_granted      <= r_need[9:0];
                    r_upd          <= 1'b1;
                end
            end else if (r_kind == cwpl_pkg::K_FREE) begin
                if (!w_entry_valid) begin
                    r_status <= cwpl_pkg::ST_NOT_FOUND;
                end else begin
                    r_valid[r_idx] <= 1'b0;
                    r_granted      <= w_entry_words;
                    r_upd          <= 1'b1;
                end
            end else if (r_kind == cwpl_pkg::K_QUERY) begin
                if (w_entry_valid) begin
                    r_granted <= w_entry_words;
                end else begin
                    r_status <= cwpl_pkg::ST_NOT_FOUND;
                end
            end else if (r_kind == cwpl_pkg::K_CLEAR) begin
                r_valid    <= '0;
                r_used_sh  <= '0;
                r_used_tx  <= '0;
                r_used_rx  <= '0;
                r_dma_held <= 1'b0;
                r_dma_ch   <= '0;
                r_dma_tx   <= 1'b0;
            end else if (r_kind == cwpl_pkg::K_DMA_GET) begin
                if (r_dma_held) begin
                    r_status <= cwpl_pkg::ST_DMA_BUSY;
                end else begin
                    r_dma_held <= 1'b1;
                    r_dma_ch   <= r_ch;
                    r_dma_tx   <= r_tx;
                end
            end else if (r_kind == cwpl_pkg::K_DMA_PUT) begin
                priority if (!r_dma_held) begin
                    r_status <= cwpl_pkg::ST_DMA_NOT_HELD;
                end else if (r_dma_ch != r_ch || r_dma_tx != r_tx) begin
                    r_status <= cwpl_pkg::ST_DMA_MISMATCH;
                end else begin
                    r_dma_held <= 1'b0;
                    r_dma_ch   <= '0;
                    r_dma_tx   <= 1'b0;
                end
            end else begin
                // Unused kinds leave everything as it is.
                r_status <= cwpl_pkg::ST_OK;
            end
        end else if (w_ctl.step == cwpl_pkg::S_COMMIT && r_upd) begin
            priority if (r_shared) begin
                r_used_sh <= w_res[9:0];
            end else if (r_tx) begin
                r_used_tx <= w_res[9:0];
            end else begin
                r_used_rx <= w_res[9:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: one transfer, shown for a single cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.last) begin
            o_status        <= r_status;
            o_granted_words <= r_granted;
            o_tx_free_words <= r_txf;
            o_rx_free_words <= w_res[9:0];
            o_dma_busy      <= r_dma_held;
        end
    end

endmodule

>>> rtl/core/cwpl_alu.sv
// Shared add and saturating subtract unit of the ledger.
module cwpl_alu (
    input  cwpl_pkg::t_alu_op   i_op,
    input  cwpl_pkg::t_alu_word i_a,
    input  cwpl_pkg::t_alu_word i_b,
    output cwpl_pkg::t_alu_word o_res,
    output logic                o_borrow
);

    logic [cwpl_pkg::ALU_W:0] w_diff;
    logic [cwpl_pkg::ALU_W:0] w_sum;

    assign w_diff   = {1'b0, i_a} - {1'b0, i_b};
    assign w_sum    = {1'b0, i_a} + {1'b0, i_b};
    assign o_borrow = w_diff[cwpl_pkg::ALU_W];

    always_comb begin
        unique case (i_op)
            cwpl_pkg::ALU_ADD:     o_res = w_sum[cwpl_pkg::ALU_W-1:0];
            cwpl_pkg::ALU_SUB_SAT: o_res = o_borrow ? '0 : w_diff[cwpl_pkg::ALU_W-1:0];
            default:               o_res = '0;
        endcase
    end

endmodule

>>> rtl/core/cwpl_seq.sv
// Step sequencer that walks one request through the shared unit.
module cwpl_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    output cwpl_pkg::t_seq_ctl o_ctl
);

    cwpl_pkg::t_step r_state;
    cwpl_pkg::t_step n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwpl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            cwpl_pkg::S_IDLE:   n_state = i_go ? cwpl_pkg::S_RSUM : cwpl_pkg::S_IDLE;
            cwpl_pkg::S_RSUM:   n_state = cwpl_pkg::S_XTX;
            cwpl_pkg::S_XTX:    n_state = cwpl_pkg::S_XRX;
            cwpl_pkg::S_XRX:    n_state = cwpl_pkg::S_AVAIL;
            cwpl_pkg::S_AVAIL:  n_state = cwpl_pkg::S_FIT;
            cwpl_pkg::S_FIT:    n_state = cwpl_pkg::S_COMMIT;
            cwpl_pkg::S_COMMIT: n_state = cwpl_pkg::S_FTX;
            cwpl_pkg::S_FTX:    n_state = cwpl_pkg::S_FRX;
            cwpl_pkg::S_FRX:    n_state = cwpl_pkg::S_IDLE;
            default:            n_state = cwpl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.step = r_state;
        o_ctl.busy = (r_state != cwpl_pkg::S_IDLE);
        o_ctl.last = (r_state == cwpl_pkg::S_FRX);
    end

endmodule

>>> rtl/core/cwpl_checker.sv
// Port-level checks of the ledger's request and result timing, with its bind.
module cwpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid
);

    // A taken request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // A result is shown for one cycle only.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A result appears only once the request has finished.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // A result always follows a busy period.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

endmodule

bind channel_word_pool_ledger cwpl_checker u_cwpl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
